// ===== rtl/keypad_scan_debounce_decoder_core_defines.svh =====
// ---------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared assertion wrappers for the keypad scan, debounce and decode core.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_DEBOUNCE_DECODER_CORE_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_DECODER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define KPSDD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define KPSDD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/kpsdd_pkg.sv =====
// ---------------------------------------------------------------------------
// Keypad scanner package
// Field widths, register indexes, decode helpers and the key value table.
// ---------------------------------------------------------------------------
package kpsdd_pkg;

    localparam int NibbleW = 4;
    localparam int DirectW = 8;
    localparam int CountW  = 8;
    localparam int IndexW  = 5;
    localparam int ValueW  = 8;
    localparam int InDataW  = 16;
    localparam int OutDataW = 16;

    // configuration register indexes
    localparam logic REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic REG_RELEASE_LIMIT  = 1'b1;

    localparam logic [CountW-1:0] DEBOUNCE_RESET = 8'd1;
    localparam logic [CountW-1:0] RELEASE_RESET  = 8'd100;

    typedef struct packed {
        logic       valid;
        logic [2:0] pos;
    } low_hot_t;

    typedef struct packed {
        logic                     mapped;
        logic signed [ValueW-1:0] value;
    } key_code_t;

    // position of the single low bit of a nibble
    function automatic low_hot_t low_hot4(input logic [NibbleW-1:0] v);
        low_hot_t r;
        r.valid = $onehot(~v);
        r.pos   = 3'd0;
        case (v)
            4'b1110: r.pos = 3'd0;
            4'b1101: r.pos = 3'd1;
            4'b1011: r.pos = 3'd2;
            4'b0111: r.pos = 3'd3;
            default: r.pos = 3'd0;
        endcase
        return r;
    endfunction

    // position of the single low bit of the direct lines
    function automatic low_hot_t low_hot8(input logic [DirectW-1:0] v);
        low_hot_t r;
        r.valid = $onehot(~v);
        r.pos   = 3'd0;
        for (int b = 0; b < DirectW; b++) begin
            if (!v[b]) begin
                r.pos = 3'(b);
            end
        end
        return r;
    endfunction

    // key index to character or special code
    function automatic key_code_t key_map(input logic [IndexW-1:0] idx);
        key_code_t k;
        k.mapped = 1'b1;
        case (idx)
            5'd0:    k.value = 8'sh31;
            5'd1:    k.value = 8'sh32;
            5'd2:    k.value = 8'sh33;
            5'd3:    k.value = 8'sh2b;
            5'd4:    k.value = 8'sh34;
            5'd5:    k.value = 8'sh35;
            5'd6:    k.value = 8'sh36;
            5'd7:    k.value = 8'sh2d;
            5'd8:    k.value = 8'sh37;
            5'd9:    k.value = 8'sh38;
            5'd10:   k.value = 8'sh39;
            5'd11:   k.value = 8'sh2a;
            5'd12:   k.value = 8'sh24;
            5'd13:   k.value = 8'sh30;
            5'd14:   k.value = 8'sh2e;
            5'd15:   k.value = 8'sh2f;
            5'd16:   k.value = 8'sh28;
            5'd17:   k.value = 8'sh29;
            5'd18:   k.value = -8'sd2;
            5'd19:   k.value = -8'sd3;
            5'd23:   k.value = -8'sd4;
            default:
            begin
                k.mapped = 1'b0;
                k.value  = -8'sd1;
            end
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/keypad_scan_debounce_decoder_core.sv =====
// ---------------------------------------------------------------------------
// Keypad scan, debounce and decode core
// Debounces a 4x4 matrix and eight direct keys and emits at most one key code per press.
// ---------------------------------------------------------------------------
// Each input transaction is one scan tick (nominally 1 ms) carrying the row
// nibble, the column nibble and the eight direct key lines, all active low.
// A press seen while idle starts a debounce wait of debounce_ticks ticks; the
// lines are then checked again and decoded into a key index (matrix 0..15 as
// row*4+col, direct 16..23), the matrix taking priority. The core then waits
// for release, or release_limit ticks, and emits the mapped key value (ASCII
// or the codes -2, -3, -4). Invalid patterns and unmapped keys emit nothing.
// Rate: one transaction per clock cycle. The state update is a single pass of
// logic from the state registers to the result register, so each result is
// registered straight from the tick that caused it. The output side is a
// result register backed by one skid entry, so input keeps flowing while a
// result waits; input stalls only when both entries are full.
// ---------------------------------------------------------------------------
`include "keypad_scan_debounce_decoder_core_defines.svh"

module keypad_scan_debounce_decoder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [kpsdd_pkg::CountW-1:0]     cfg_wdata,
    // scan tick stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] row_sense, [7:4] col_sense, [15:8] direct_lines
    input  logic [kpsdd_pkg::InDataW-1:0]    s_tdata,
    // key stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] key_value (signed), [12:8] key_index, [15:13] zero
    output logic [kpsdd_pkg::OutDataW-1:0]   m_tdata
);
    import kpsdd_pkg::*;

    // phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DEB_MAT  = 3'd1;
    localparam logic [2:0] PH_DEB_DIR  = 3'd2;
    localparam logic [2:0] PH_WAIT_MAT = 3'd3;
    localparam logic [2:0] PH_WAIT_DIR = 3'd4;

    // configuration registers
    logic [CountW-1:0] debounce_ticks_reg;
    logic [CountW-1:0] release_limit_reg;

    // scan state
    logic [2:0]        phase_reg,      phase_next;
    logic [CountW-1:0] tick_count_reg, tick_count_next;
    logic [IndexW-1:0] held_index_reg, held_index_next;
    logic              held_valid_reg, held_valid_next;

    // output register and skid entry
    logic                     out_valid_reg,  out_valid_next;
    logic signed [ValueW-1:0] out_value_reg,  out_value_next;
    logic [IndexW-1:0]        out_index_reg,  out_index_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic signed [ValueW-1:0] skid_value_reg, skid_value_next;
    logic [IndexW-1:0]        skid_index_reg, skid_index_next;

    logic [NibbleW-1:0] row_sense;
    logic [NibbleW-1:0] col_sense;
    logic [DirectW-1:0] direct_lines;

    logic                     in_accept;
    logic                     out_pop;
    logic                     res_valid;
    logic signed [ValueW-1:0] res_value;
    logic [IndexW-1:0]        res_index;

    assign row_sense    = s_tdata[3:0];
    assign col_sense    = s_tdata[7:4];
    assign direct_lines = s_tdata[15:8];

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_index_reg, out_value_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            release_limit_reg  <= RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_wdata;
                REG_RELEASE_LIMIT:  release_limit_reg  <= cfg_wdata;
                default:            debounce_ticks_reg <= debounce_ticks_reg;
            endcase
        end
    end

    // scan state machine: one tick per accepted transaction
    always_comb
    begin
        logic [CountW-1:0] tick_inc;
        low_hot_t          r_pos;
        low_hot_t          c_pos;
        low_hot_t          d_pos;
        logic              matrix;
        logic              released;
        logic              finish;
        logic              fin_valid;
        logic [IndexW-1:0] fin_index;
        key_code_t         code;

        tick_inc  = (tick_count_reg == '1) ? tick_count_reg : tick_count_reg + 1'b1;
        r_pos     = low_hot4(row_sense);
        c_pos     = low_hot4(col_sense);
        d_pos     = low_hot8(direct_lines);
        matrix    = 1'b0;
        released  = 1'b0;
        finish    = 1'b0;
        fin_valid = held_valid_reg;
        fin_index = held_index_reg;

        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        held_index_next = held_index_reg;
        held_valid_next = held_valid_reg;

        if (in_accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (row_sense != 4'hf)
                    begin
                        phase_next      = PH_DEB_MAT;
                        tick_count_next = '0;
                    end
                    else if (direct_lines != 8'hff)
                    begin
                        phase_next      = PH_DEB_DIR;
                        tick_count_next = '0;
                    end
                end
                PH_DEB_MAT, PH_DEB_DIR:
                begin
                    matrix          = (phase_reg == PH_DEB_MAT);
                    tick_count_next = tick_inc;
                    if (tick_inc >= debounce_ticks_reg)
                    begin
                        if ((matrix && row_sense == 4'hf)
                            || (!matrix && direct_lines == 8'hff))
                        begin
                            // press gone at recheck: drop it
                            phase_next      = PH_IDLE;
                            tick_count_next = '0;
                        end
                        else
                        begin
                            if (matrix)
                            begin
                                // bit 3 low is row 0 / column 0
                                fin_valid = r_pos.valid && c_pos.valid;
                                fin_index = fin_valid
                                    ? {1'b0, ~r_pos.pos[1:0], ~c_pos.pos[1:0]} : '0;
                                released  = (col_sense == 4'hf);
                            end
                            else
                            begin
                                fin_valid = d_pos.valid;
                                fin_index = fin_valid ? {2'b10, d_pos.pos} : '0;
                                released  = 1'b0;
                            end
                            held_valid_next = fin_valid;
                            held_index_next = fin_index;
                            if (released || release_limit_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                phase_next      = matrix ? PH_WAIT_MAT : PH_WAIT_DIR;
                                tick_count_next = '0;
                            end
                        end
                    end
                end
                PH_WAIT_MAT, PH_WAIT_DIR:
                begin
                    released = (phase_reg == PH_WAIT_MAT) ? (col_sense == 4'hf)
                                                          : (direct_lines == 8'hff);
                    tick_count_next = tick_inc;
                    if (released || tick_inc >= release_limit_reg)
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                end
            endcase
        end

        code = key_map(fin_index);
        if (finish)
        begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
        end
        res_valid = finish && fin_valid && code.mapped;
        res_value = code.value;
        res_index = fin_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            held_index_reg <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            held_index_reg <= held_index_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // result register and skid entry: hold a stalled result, park the next one
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        skid_valid_next = skid_valid_reg;
        skid_value_next = skid_value_reg;
        skid_index_next = skid_index_reg;

        if (skid_valid_reg)
        begin
            // input is stalled here, so no new result arrives
            if (out_pop)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = skid_value_reg;
                out_index_next  = skid_index_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_pop)
        begin
            out_valid_next = res_valid && in_accept;
            out_value_next = res_value;
            out_index_next = res_index;
        end
        else if (res_valid && in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_value_next = res_value;
            skid_index_next = res_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        skid_value_reg <= skid_value_next;
        skid_index_reg <= skid_index_next;
    end

    `KPSDD_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg,
                  "skid entry full while result register empty")
    `KPSDD_ASSERT(a_idle_count_zero, (phase_reg == PH_IDLE) |-> (tick_count_reg == '0),
                  "tick count not cleared in idle")
    `KPSDD_ASSERT(a_out_index_range, out_valid_reg |-> (out_index_reg <= 5'd23),
                  "emitted key index out of range")
    `KPSDD_ASSERT(a_out_mapped, out_valid_reg |-> (out_value_reg != -8'sd1),
                  "unmapped key emitted")
    `KPSDD_ASSERT_ALWAYS(a_no_skid_in_reset, !rst_n |=> !skid_valid_reg,
                         "skid entry set during reset")

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Keypad scan, debounce and decode core testbench
// Streams scan ticks into the core, predicts each emitted key with an
// independent model of the debounce and release state machine, and checks
// every key transaction against the oldest expectation.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kpsdd_pkg::*;

    // predictor phase: matrix and direct keys are tracked separately
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_DEB_MAT,
        SCAN_DEB_DIR,
        SCAN_WAIT_MAT,
        SCAN_WAIT_DIR
    } scan_phase_t;

    // one key transaction, laid out as m_tdata[12:0]
    typedef struct packed {
        logic [IndexW-1:0] index;
        logic [ValueW-1:0] value;
    } key_event_t;

    // one row of the directed table: the tick and, where obvious, its key
    typedef struct packed {
        logic [DirectW-1:0] dir;
        logic [NibbleW-1:0] col;
        logic [NibbleW-1:0] row;
        logic               fixed;
        key_event_t         want;
    } scan_row_t;

    localparam logic [7:0]  NO_KEY   = 8'hff;   // -1: key has no code
    localparam logic [15:0] ALL_UP   = 16'hffff;
    localparam logic [3:0]  NIB_UP   = 4'hf;
    localparam logic [7:0]  DIR_UP   = 8'hff;
    localparam int          PHASES   = 9;
    // printable keys 0..17, first character in the top byte
    localparam logic [8*18-1:0] KEY_TEXT = "123+456-789*$0./()";

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = REG_DEBOUNCE_TICKS;
    logic [CountW-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata = ALL_UP;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [OutDataW-1:0]  m_tdata;

    // side channel travelling with each tick: a typed-in expectation
    logic                 tick_fixed = 1'b0;
    key_event_t           fixed_key = '0;

    // predictor state and its copy of the registers
    scan_phase_t          scan_phase;
    logic [CountW-1:0]    scan_count;
    logic [IndexW-1:0]    held_key;
    logic                 held_ok;
    logic [CountW-1:0]    debounce_ticks;
    logic [CountW-1:0]    release_limit;

    key_event_t           key_events_due[$];
    int                   err_count = 0;
    int                   ticks_sent = 0;
    int                   src_pct = 0;     // chance in a hundred the sender idles
    int                   snk_pct = 0;     // chance in a hundred the receiver stalls

    keypad_scan_debounce_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // the run must end long before this; a hang lands here
    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // position of the single low bit, or -1 when none or several are low
    function automatic int zero_pos(input logic [7:0] v, input int width);
        int pos;
        pos = -1;
        for (int b = 0; b < width; b++)
        begin
            if (!v[b])
            begin
                if (pos >= 0)
                    return -1;
                pos = b;
            end
        end
        return pos;
    endfunction

    function automatic logic [7:0] key_char(input logic [IndexW-1:0] idx);
        if (idx < 18)
            return KEY_TEXT[8*(17 - idx) +: 8];
        case (idx)
            5'd18:   return 8'hfe;    // -2
            5'd19:   return 8'hfd;    // -3
            5'd23:   return 8'hfc;    // -4
            default: return NO_KEY;   // 20..22 stay silent
        endcase
    endfunction

    // drop back to idle and hand out the held key if it is a real one
    task automatic release_key(output bit emit, output key_event_t ev);
        scan_phase = SCAN_IDLE;
        scan_count = '0;
        emit = 1'b0;
        ev = '0;
        if (held_ok && key_char(held_key) != NO_KEY)
        begin
            emit = 1'b1;
            ev.value = key_char(held_key);
            ev.index = held_key;
        end
    endtask

    // advance the predictor by one scan tick
    task automatic decode_tick(input logic [3:0] row, input logic [3:0] col,
                               input logic [7:0] dir, output bit emit,
                               output key_event_t ev);
        int  r;
        int  c;
        int  d;
        bit  on_matrix;
        bit  released;
        emit = 1'b0;
        ev = '0;
        case (scan_phase)
            SCAN_IDLE:
            begin
                // matrix wins over the direct lines
                if (row != NIB_UP)
                begin
                    scan_phase = SCAN_DEB_MAT;
                    scan_count = '0;
                end
                else if (dir != DIR_UP)
                begin
                    scan_phase = SCAN_DEB_DIR;
                    scan_count = '0;
                end
            end
            SCAN_DEB_MAT, SCAN_DEB_DIR:
            begin
                on_matrix = (scan_phase == SCAN_DEB_MAT);
                if (scan_count != 8'hff)
                    scan_count++;
                // a zero debounce setting falls through on the first pass
                if (scan_count >= debounce_ticks)
                begin
                    if (on_matrix ? (row == NIB_UP) : (dir == DIR_UP))
                    begin
                        // press vanished before the recheck
                        scan_phase = SCAN_IDLE;
                        scan_count = '0;
                    end
                    else
                    begin
                        if (on_matrix)
                        begin
                            // bit 3 low is row 0 / column 0
                            r = zero_pos({4'hf, row}, 4);
                            c = zero_pos({4'hf, col}, 4);
                            held_ok = (r >= 0 && c >= 0);
                            held_key = held_ok ? IndexW'((3 - r) * 4 + (3 - c)) : '0;
                            released = (col == NIB_UP);
                        end
                        else
                        begin
                            d = zero_pos(dir, 8);
                            held_ok = (d >= 0);
                            held_key = held_ok ? IndexW'(16 + d) : '0;
                            released = (dir == DIR_UP);
                        end
                        if (released || release_limit == 0)
                            release_key(emit, ev);
                        else
                        begin
                            scan_phase = on_matrix ? SCAN_WAIT_MAT : SCAN_WAIT_DIR;
                            scan_count = '0;
                        end
                    end
                end
            end
            SCAN_WAIT_MAT, SCAN_WAIT_DIR:
            begin
                released = (scan_phase == SCAN_WAIT_MAT) ? (col == NIB_UP)
                                                         : (dir == DIR_UP);
                if (scan_count != 8'hff)
                    scan_count++;
                if (released || scan_count >= release_limit)
                    release_key(emit, ev);
            end
            default:
            begin
                scan_phase = SCAN_IDLE;
                scan_count = '0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: every edge, take register writes, then accepted ticks,
    // then compare an accepted key transaction with the oldest expectation.
    // All inputs are sampled before the edge's own updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        bit         emit;
        key_event_t ev;
        key_event_t want;
        if (!rst_n)
        begin
            scan_phase = SCAN_IDLE;
            scan_count = '0;
            held_key = '0;
            held_ok = 1'b0;
            debounce_ticks = DEBOUNCE_RESET;
            release_limit = RELEASE_RESET;
            key_events_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEBOUNCE_TICKS)
                    debounce_ticks = cfg_wdata;
                else
                    release_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                decode_tick(s_tdata[3:0], s_tdata[7:4], s_tdata[15:8], emit, ev);
                if (tick_fixed)
                    key_events_due.push_back(fixed_key);
                else if (emit)
                    key_events_due.push_back(ev);
            end
            if (m_tvalid && m_tready)
            begin
                if (key_events_due.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected key transaction: value %0d index %0d",
                                 $signed(m_tdata[7:0]), m_tdata[12:8]);
                end
                else
                begin
                    want = key_events_due.pop_front();
                    if (m_tdata[7:0] !== want.value || m_tdata[12:8] !== want.index)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("key mismatch: value exp %0d got %0d, index exp %0d got %0d",
                                     $signed(want.value), $signed(m_tdata[7:0]),
                                     want.index, m_tdata[12:8]);
                    end
                end
            end
        end
    end

    // receiver back-pressure, retuned per phase
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_pct);

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // offer one tick, idling first at the phase's rate; return once accepted
    task automatic send_tick(input logic [15:0] data, input bit fixed,
                             input key_event_t want);
        while (src_pct != 0 && $urandom_range(99) < src_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        tick_fixed <= fixed;
        fixed_key <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // one press or a burst of line noise: maybe some contact bounce, a hold of random length, release
    task automatic press_key(input int deb, input int rel);
        int          kind;
        int          hold;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [7:0]  dir;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // plain line noise
            repeat ($urandom_range(4, 1))
                send_tick(16'($urandom), 1'b0, '0);
            return;
        end
        row = NIB_UP;
        col = NIB_UP;
        dir = DIR_UP;
        if (kind < 62)
        begin
            row = ~(4'b0001 << $urandom_range(3));
            col = ~(4'b0001 << $urandom_range(3));
            // direct lines are ignored while the matrix is tracked
            if ($urandom_range(3) == 0)
                dir = 8'($urandom);
        end
        else if (kind < 84)
        begin
            dir = ~(8'h01 << $urandom_range(7));
            col = 4'($urandom);
        end
        else
        begin
            row = 4'($urandom);
            col = 4'($urandom);
            dir = 8'($urandom);
        end
        repeat ($urandom_range(2))
        begin
            send_tick({dir, col, row}, 1'b0, '0);
            send_tick(ALL_UP, 1'b0, '0);
        end
        // a hold of exactly the debounce length lets go on the recheck tick
        hold = (deb == 0) ? 1 : deb;
        hold += ($urandom_range(7) == 0) ? $urandom_range(rel + 2) : $urandom_range(4);
        repeat (hold)
            send_tick({dir, col, row}, 1'b0, '0);
        repeat ($urandom_range(3, 1))
            send_tick(ALL_UP, 1'b0, '0);
    endtask

    // feed released ticks until the predictor is back in idle, then wait
    // for every expected key and the core's latency
    task automatic settle_and_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (scan_phase != SCAN_IDLE)
        begin
            send_tick(ALL_UP, 1'b0, '0);
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (key_events_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(input logic [7:0] deb, input logic [7:0] rel);
        cfg_we <= 1'b1;
        cfg_index <= REG_DEBOUNCE_TICKS;
        cfg_wdata <= deb;
        @(posedge clk);
        cfg_index <= REG_RELEASE_LIMIT;
        cfg_wdata <= rel;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        scan_row_t directed [25];
        int        deb_set [PHASES];
        int        rel_set [PHASES];
        int        src_set [PHASES];
        int        snk_set [PHASES];
        int        budget  [PHASES];
        int        start;

        // reset values hold for the directed rows: one tick of debounce
        directed = '{
            // top-left key '1': press, recheck, release
            '{8'hff, 4'h7, 4'h7, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'h7, 4'h7, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b1, '{5'd0,  8'h31}},
            // bottom-right key '/'
            '{8'hff, 4'he, 4'he, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'he, 4'he, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b1, '{5'd15, 8'h2f}},
            // top direct line, code -4
            '{8'h7f, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            '{8'h7f, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b1, '{5'd23, 8'hfc}},
            // direct line 2, code -2
            '{8'hfb, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            '{8'hfb, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b1, '{5'd18, 8'hfe}},
            // press gone by the recheck
            '{8'hff, 4'h7, 4'h7, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            // two rows low: invalid, waits for release, stays silent
            '{8'hff, 4'h7, 4'h3, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'h7, 4'h3, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            // unmapped direct key: silent
            '{8'hef, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            '{8'hef, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b0, '{5'd0,  8'h00}},
            // matrix and direct together: matrix key '5' wins
            '{8'hfe, 4'hb, 4'hb, 1'b0, '{5'd0,  8'h00}},
            '{8'hfe, 4'hb, 4'hb, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hf, 1'b1, '{5'd5,  8'h35}},
            // columns released on the recheck: no valid column, silent
            '{8'hff, 4'hd, 4'hd, 1'b0, '{5'd0,  8'h00}},
            '{8'hff, 4'hf, 4'hd, 1'b0, '{5'd0,  8'h00}}
        };

        // register settings and idling per phase; phase 0 keeps reset values
        deb_set = '{1,   2,  0, 4, 255,   1, 255, 0, 1};
        rel_set = '{100, 3,  0, 1, 255, 255,   1, 0, 2};
        src_set = '{0,  73,  0, 8,   0,  73,   0, 8, 0};
        snk_set = '{0,   0, 73, 8,   0,   0,  73, 8, 0};
        budget  = '{180, 180, 180, 180, 300, 180, 300, 180, 180};
        deb_set[7] = $urandom_range(8, 1);
        rel_set[7] = $urandom_range(12, 1);

        // hold reset, then release it for good
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_tick({directed[k].dir, directed[k].col, directed[k].row},
                      directed[k].fixed, directed[k].want);

        for (int p = 0; p < PHASES; p++)
        begin
            // registers change only with the core idle and nothing in flight
            if (p != 0)
            begin
                settle_and_drain();
                write_limits(8'(deb_set[p]), 8'(rel_set[p]));
            end
            src_pct = src_set[p];
            snk_pct = snk_set[p];
            start = ticks_sent;
            while (ticks_sent - start < budget[p])
                press_key(deb_set[p], rel_set[p]);
        end

        // drop valid, let every key arrive, then allow for the pipeline
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (key_events_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kpsdd_pkg.sv
rtl/keypad_scan_debounce_decoder_core.sv
test/testbench.sv
